FILE: src/pqms_pkg.sv
// package for the priority queue min scan block: codes, default sizes and the
// command/status structs between controller and datapath; no dependencies
package pqms_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int BURST_BITS_DEF  = 16;
	localparam int PRIO_BITS_DEF   = 8;

	typedef logic [1:0] cmd_t;
	typedef logic [1:0] status_t;

	localparam cmd_t CMD_ENQ  = 2'd0;
	localparam cmd_t CMD_DEQ  = 2'd1;
	localparam cmd_t CMD_PEEK = 2'd2;

	localparam status_t ST_DONE  = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic    accept;
		status_t stat;
		logic    enq_write;
		logic    scan_start;
		logic    scan_step;
		logic    shift_prep;
		logic    shift_step;
		logic    count_dec;
		logic    load_out;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
		logic scan_last;
		logic need_shift;
		logic shift_last;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: src/pqms_req_if.sv
// request channel of the priority queue block: valid/ready plus command payload
// depends on pqms_pkg
interface pqms_req_if #(
	parameter int BURST_BITS = pqms_pkg::BURST_BITS_DEF,
	parameter int PRIO_BITS  = pqms_pkg::PRIO_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	pqms_pkg::cmd_t        cmd;
	logic [BURST_BITS-1:0] burst_time;
	logic [PRIO_BITS-1:0]  priority_req;

	modport source (output valid, output cmd, output burst_time, output priority_req,
		input ready);
	modport sink (input valid, input cmd, input burst_time, input priority_req,
		output ready);
endinterface

FILE: src/pqms_rsp_if.sv
// response channel of the priority queue block: valid/ready plus result payload
// depends on pqms_pkg
interface pqms_rsp_if #(
	parameter int BURST_BITS = pqms_pkg::BURST_BITS_DEF,
	parameter int PRIO_BITS  = pqms_pkg::PRIO_BITS_DEF,
	parameter int CNT_W      = $clog2(pqms_pkg::QUEUE_DEPTH_DEF + 1)
);
	logic                  valid;
	logic                  ready;
	pqms_pkg::status_t     status;
	logic [BURST_BITS-1:0] best_burst;
	logic [PRIO_BITS-1:0]  best_priority;
	logic [CNT_W-1:0]      entry_count;

	modport source (output valid, output status, output best_burst, output best_priority,
		output entry_count, input ready);
	modport sink (input valid, input status, input best_burst, input best_priority,
		input entry_count, output ready);
endinterface

FILE: src/priority_queue_min_scan_core.sv
// top level of the priority queue min scan block: controller, datapath and
// channel wiring; depends on pqms_pkg, pqms_req_if, pqms_rsp_if, pqms_ctrl, pqms_datapath

// The block keeps up to QUEUE_DEPTH entries, each a burst time and a priority,
// in insertion order in a single-port-read ram. One request item is worked on at
// a time and yields exactly one response item. Enqueue and every rejected request
// (enqueue when full, peek or dequeue when empty, the unused command) go from
// accept straight to the result load. Peek first runs a scan that reads one entry
// per cycle through the ram read port. Dequeue adds a setup step after the scan
// and then closes the gap behind the removed entry by copying entries down one
// per cycle through the same port. A new request is taken as soon as the block is
// back at rest, even while the previous response still waits in the output
// register. The store needs no clearing pass after reset: only entries below the
// fill count are ever read.
module priority_queue_min_scan_core #(
	parameter int QUEUE_DEPTH = pqms_pkg::QUEUE_DEPTH_DEF,
	parameter int BURST_BITS  = pqms_pkg::BURST_BITS_DEF,
	parameter int PRIO_BITS   = pqms_pkg::PRIO_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	pqms_req_if.sink  req,
	pqms_rsp_if.source rsp
);
	import pqms_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	// control and status between the two halves
	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;
	logic     ctrl_ready;

	// request side: ready only while the controller is at rest
	assign req.ready = ctrl_ready;

	pqms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_cmd   (req.cmd),
		.in_ready (ctrl_ready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	// datapath holds the store, the fill count and the response register
	pqms_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.BURST_BITS  (BURST_BITS),
		.PRIO_BITS   (PRIO_BITS),
		.CNT_W       (CNT_W)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (dp_cmd),
		.stat       (dp_stat),
		.in_burst   (req.burst_time),
		.in_prio    (req.priority_req),
		.out_ready  (rsp.ready),
		.out_valid  (rsp.valid),
		.out_status (rsp.status),
		.out_burst  (rsp.best_burst),
		.out_prio   (rsp.best_priority),
		.out_count  (rsp.entry_count)
	);
endmodule

FILE: src/pqms_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module pqms_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

FILE: src/pqms_ctrl.sv
// controller state machine of the priority queue: sequences accept, scan,
// shift and result load; depends on pqms_pkg
module pqms_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  pqms_pkg::cmd_t     in_cmd,
	output logic               in_ready,
	input  pqms_pkg::dp_stat_t stat,
	output pqms_pkg::dp_cmd_t  cmd
);
	import pqms_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_PREP   = 3'd2;
	localparam logic [2:0] S_SHIFT  = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	logic [2:0] state_q, state_d;
	logic       is_deq_q, is_deq_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			is_deq_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			is_deq_q <= is_deq_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d  = state_q;
		is_deq_d = is_deq_q;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					cmd.stat   = ST_DONE;
					state_d    = S_FINISH;
					case (in_cmd)
						CMD_ENQ: begin
							if (stat.full) begin
								cmd.stat = ST_FULL;
							end else begin
								cmd.enq_write = 1'b1;
							end
						end
						CMD_DEQ, CMD_PEEK: begin
							if (stat.empty) begin
								cmd.stat = ST_EMPTY;
							end else begin
								cmd.scan_start = 1'b1;
								state_d        = S_SCAN;
							end
						end
						default: begin
						end
					endcase
					is_deq_d = (in_cmd == CMD_DEQ);
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = is_deq_q ? S_PREP : S_FINISH;
				end
			end
			S_PREP: begin
				if (stat.need_shift) begin
					cmd.shift_prep = 1'b1;
					state_d        = S_SHIFT;
				end else begin
					cmd.count_dec = 1'b1;
					state_d       = S_FINISH;
				end
			end
			S_SHIFT: begin
				cmd.shift_step = 1'b1;
				if (stat.shift_last) begin
					cmd.count_dec = 1'b1;
					state_d       = S_FINISH;
				end
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

FILE: src/pqms_datapath.sv
// datapath of the priority queue: entry ram, fill count, scan and shift
// indexes, best-entry register and output register; depends on pqms_pkg, pqms_ram
module pqms_datapath #(
	parameter int QUEUE_DEPTH = pqms_pkg::QUEUE_DEPTH_DEF,
	parameter int BURST_BITS  = pqms_pkg::BURST_BITS_DEF,
	parameter int PRIO_BITS   = pqms_pkg::PRIO_BITS_DEF,
	parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pqms_pkg::dp_cmd_t     cmd,
	output pqms_pkg::dp_stat_t    stat,
	input  logic [BURST_BITS-1:0] in_burst,
	input  logic [PRIO_BITS-1:0]  in_prio,
	input  logic                  out_ready,
	output logic                  out_valid,
	output pqms_pkg::status_t     out_status,
	output logic [BURST_BITS-1:0] out_burst,
	output logic [PRIO_BITS-1:0]  out_prio,
	output logic [CNT_W-1:0]      out_count
);
	import pqms_pkg::*;

	localparam int ADDR_W = $clog2(QUEUE_DEPTH);
	localparam int KEY_W  = PRIO_BITS + BURST_BITS;

	// entries are stored as {priority, burst} so one compare orders them
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  rd_idx_q;
	logic [ADDR_W-1:0] cmp_idx_q;
	logic [ADDR_W-1:0] wr_idx_q;
	logic [ADDR_W-1:0] best_idx_q;
	logic [KEY_W-1:0]  best_key_q;
	status_t           stat_q;
	logic              has_best_q;

	logic              out_valid_q;
	status_t           out_status_q;
	logic [KEY_W-1:0]  out_key_q;
	logic [CNT_W-1:0]  out_count_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [KEY_W-1:0]  ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [KEY_W-1:0]  ram_rdata;
	logic [CNT_W-1:0]  best_next;

	assign best_next = CNT_W'(best_idx_q) + CNT_W'(1);

	assign ram_we    = cmd.enq_write | cmd.shift_step;
	assign ram_waddr = cmd.enq_write ? count_q[ADDR_W-1:0] : wr_idx_q;
	assign ram_wdata = cmd.enq_write ? {in_prio, in_burst} : ram_rdata;

	always_comb begin
		if (cmd.scan_start) begin
			ram_raddr = '0;
		end else if (cmd.shift_prep) begin
			ram_raddr = best_next[ADDR_W-1:0];
		end else begin
			ram_raddr = rd_idx_q[ADDR_W-1:0];
		end
	end

	pqms_ram #(
		.WIDTH (KEY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign stat.empty      = (count_q == '0);
	assign stat.full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.scan_last  = (CNT_W'(cmp_idx_q) + CNT_W'(1) == count_q);
	assign stat.need_shift = (best_next < count_q);
	assign stat.shift_last = (CNT_W'(wr_idx_q) + CNT_W'(2) == count_q);
	assign stat.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.enq_write) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.count_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			stat_q     <= cmd.stat;
			has_best_q <= cmd.scan_start;
		end
		if (cmd.scan_start) begin
			rd_idx_q  <= CNT_W'(1);
			cmp_idx_q <= '0;
		end
		if (cmd.scan_step) begin
			// first entry seeds the best; later ones replace it only when strictly lower
			if (cmp_idx_q == '0 || ram_rdata < best_key_q) begin
				best_key_q <= ram_rdata;
				best_idx_q <= cmp_idx_q;
			end
			cmp_idx_q <= cmp_idx_q + ADDR_W'(1);
		end
		if (cmd.shift_prep) begin
			rd_idx_q <= best_next + CNT_W'(1);
			wr_idx_q <= best_idx_q;
		end
		if (cmd.shift_step) begin
			wr_idx_q <= wr_idx_q + ADDR_W'(1);
		end
		if ((cmd.scan_step || cmd.shift_step) && rd_idx_q < count_q) begin
			rd_idx_q <= rd_idx_q + CNT_W'(1);
		end
		if (cmd.load_out) begin
			out_status_q <= stat_q;
			out_key_q    <= has_best_q ? best_key_q : '0;
			out_count_q  <= count_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_burst  = out_key_q[BURST_BITS-1:0];
	assign out_prio   = out_key_q[KEY_W-1:BURST_BITS];
	assign out_count  = out_count_q;
endmodule

FILE: src/pqms_checker.sv
// port-level assertions for the priority queue block and their bind
// depends on pqms_pkg and priority_queue_min_scan_core
module pqms_checker #(
	parameter int QUEUE_DEPTH = pqms_pkg::QUEUE_DEPTH_DEF,
	parameter int BURST_BITS  = pqms_pkg::BURST_BITS_DEF,
	parameter int PRIO_BITS   = pqms_pkg::PRIO_BITS_DEF,
	parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_valid,
	input logic                  req_ready,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input pqms_pkg::status_t     rsp_status,
	input logic [BURST_BITS-1:0] rsp_burst,
	input logic [PRIO_BITS-1:0]  rsp_prio,
	input logic [CNT_W-1:0]      rsp_count
);
	import pqms_pkg::*;

	// one item at a time: ready drops right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted back to back");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_count <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count beyond depth");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |->
			rsp_count == CNT_W'(QUEUE_DEPTH) && rsp_burst == '0 && rsp_prio == '0)
		else $error("full status with wrong fields");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_EMPTY |->
			rsp_count == '0 && rsp_burst == '0 && rsp_prio == '0)
		else $error("empty status with wrong fields");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_count))
		else $error("stalled response changed");
endmodule

bind priority_queue_min_scan_core pqms_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH),
	.BURST_BITS  (BURST_BITS),
	.PRIO_BITS   (PRIO_BITS)
) u_pqms_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_burst  (rsp.best_burst),
	.rsp_prio   (rsp.best_priority),
	.rsp_count  (rsp.entry_count)
);
